@@ design/sppt_pkg.sv @@
// Shared types and constants for the strong probable prime test.
`default_nettype none
package sppt_pkg;

  localparam int WIDTH = 64;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operand selection and destination for the modular multiplier
  typedef enum logic [1:0] {
    OP_RED,   // base mod n     -> bb
    OP_MUL,   // r * bb mod n   -> r
    OP_SQB,   // bb * bb mod n  -> bb
    OP_SQR    // r * r mod n    -> r
  } mm_op_t;

  typedef struct packed {
    logic   load;
    logic   split;
    logic   mm_start;
    mm_op_t op;
    logic   exp_shift;
    logic   s_dec;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic n_two;
    logic e_odd;
    logic e_last;
    logic s_zero;
    logic r_one;
    logic r_nm1;
    logic mm_done;
  } stat_t;

endpackage
`default_nettype wire

@@ design/sppt_modmul.sv @@
// Shift-and-add modular multiplier, one add-and-reduce per cycle.
`default_nettype none
module sppt_modmul (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire sppt_pkg::word_t a,
  input  wire sppt_pkg::word_t mult,
  input  wire sppt_pkg::word_t m,
  output logic                done,
  output sppt_pkg::word_t     prod
);

  sppt_pkg::word_t acc;
  sppt_pkg::word_t a_r;
  sppt_pkg::word_t m_r;
  sppt_pkg::word_t mult_r;
  sppt_pkg::cnt_t  cnt;
  logic            add_phase;
  logic            running;
  logic            last_bit;

  sppt_pkg::word_t               addend;
  logic [sppt_pkg::WIDTH:0]      sum;
  logic [sppt_pkg::WIDTH+1:0]    diff;
  sppt_pkg::word_t               acc_next;

  // doubling step adds acc to itself, add step adds a; both < m
  assign addend   = add_phase ? a_r : acc;
  assign sum      = {1'b0, acc} + {1'b0, addend};
  assign diff     = {1'b0, sum} - {2'b00, m_r};
  assign acc_next = diff[sppt_pkg::WIDTH+1] ? sum[sppt_pkg::WIDTH-1:0]
                                            : diff[sppt_pkg::WIDTH-1:0];
  assign last_bit = (cnt == sppt_pkg::CNT_W'(sppt_pkg::WIDTH - 1));
  assign prod     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && !(!add_phase && mult_r[sppt_pkg::WIDTH-1]) && last_bit) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc       <= '0;
      a_r       <= a;
      m_r       <= m;
      mult_r    <= mult;
      cnt       <= '0;
      add_phase <= 1'b0;
    end else if (running) begin
      acc <= acc_next;
      if (!add_phase && mult_r[sppt_pkg::WIDTH-1]) begin
        add_phase <= 1'b1;
      end else begin
        add_phase <= 1'b0;
        mult_r    <= mult_r << 1;
        cnt       <= cnt + sppt_pkg::cnt_t'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/sppt_datapath.sv @@
// Operand registers, exponent split and multiplier for the prime test.
`default_nettype none
module sppt_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sppt_pkg::word_t candidate,
  input  wire sppt_pkg::word_t base,
  input  wire sppt_pkg::cmd_t  cmd,
  output sppt_pkg::stat_t      stat
);

  sppt_pkg::word_t n;
  sppt_pkg::word_t bb;
  sppt_pkg::word_t r;
  sppt_pkg::word_t e;
  sppt_pkg::cnt_t  s;
  sppt_pkg::mm_op_t op_r;

  sppt_pkg::word_t nm1;
  sppt_pkg::word_t mm_a;
  sppt_pkg::word_t mm_mult;
  sppt_pkg::word_t mm_prod;
  logic            mm_done;

  assign nm1 = n - sppt_pkg::word_t'(1);

  always_comb begin
    unique case (cmd.op)
      sppt_pkg::OP_RED: begin
        mm_a    = sppt_pkg::word_t'(1);
        mm_mult = bb;
      end
      sppt_pkg::OP_MUL: begin
        mm_a    = r;
        mm_mult = bb;
      end
      sppt_pkg::OP_SQB: begin
        mm_a    = bb;
        mm_mult = bb;
      end
      default: begin
        mm_a    = r;
        mm_mult = r;
      end
    endcase
  end

  sppt_modmul u_mm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mm_start),
    .a     (mm_a),
    .mult  (mm_mult),
    .m     (n),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n  <= candidate;
      bb <= base;
      r  <= sppt_pkg::word_t'(1);
      e  <= candidate - sppt_pkg::word_t'(1);
      s  <= '0;
    end else begin
      if (cmd.split) begin
        e <= e >> 1;
        s <= s + sppt_pkg::cnt_t'(1);
      end
      if (cmd.exp_shift) begin
        e <= e >> 1;
      end
      if (cmd.s_dec) begin
        s <= s - sppt_pkg::cnt_t'(1);
      end
      if (mm_done) begin
        case (op_r) inside
          sppt_pkg::OP_RED, sppt_pkg::OP_SQB: bb <= mm_prod;
          default:                            r  <= mm_prod;
        endcase
      end
    end
    if (cmd.mm_start) begin
      op_r <= cmd.op;
    end
  end

  assign stat.n_small = (n[sppt_pkg::WIDTH-1:2] == '0) && !(n[1] && n[0]);
  assign stat.n_two   = (n == sppt_pkg::word_t'(2));
  assign stat.e_odd   = e[0];
  assign stat.e_last  = (e[sppt_pkg::WIDTH-1:1] == '0);
  assign stat.s_zero  = (s == '0);
  assign stat.r_one   = (r == sppt_pkg::word_t'(1));
  assign stat.r_nm1   = (r == nm1);
  assign stat.mm_done = mm_done;

endmodule
`default_nettype wire

@@ design/sppt_ctrl.sv @@
// Sequencer for the strong probable prime test.
`default_nettype none
module sppt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire sppt_pkg::stat_t stat,
  output sppt_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done,
  output logic                 is_probable_prime
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SPLIT  = 4'd2;
  localparam logic [3:0] S_RED_W  = 4'd3;
  localparam logic [3:0] S_EXP    = 4'd4;
  localparam logic [3:0] S_MUL_W  = 4'd5;
  localparam logic [3:0] S_SQB_W  = 4'd6;
  localparam logic [3:0] S_TEST   = 4'd7;
  localparam logic [3:0] S_SQ_CHK = 4'd8;
  localparam logic [3:0] S_SQR_W  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       fin;
  logic       fin_val;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = sppt_pkg::OP_RED;
    fin        = 1'b0;
    fin_val    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.n_small) begin
          fin     = 1'b1;
          fin_val = stat.n_two;
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!stat.e_odd) begin
          cmd.split = 1'b1;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.op       = sppt_pkg::OP_RED;
          state_next   = S_RED_W;
        end
      end
      S_RED_W: begin
        if (stat.mm_done) state_next = S_EXP;
      end
      S_EXP: begin
        cmd.mm_start = 1'b1;
        if (stat.e_odd) begin
          cmd.op     = sppt_pkg::OP_MUL;
          state_next = S_MUL_W;
        end else begin
          cmd.op     = sppt_pkg::OP_SQB;
          state_next = S_SQB_W;
        end
      end
      S_MUL_W: begin
        if (stat.mm_done) begin
          if (stat.e_last) begin
            state_next = S_TEST;
          end else begin
            cmd.mm_start = 1'b1;
            cmd.op       = sppt_pkg::OP_SQB;
            state_next   = S_SQB_W;
          end
        end
      end
      S_SQB_W: begin
        if (stat.mm_done) begin
          cmd.exp_shift = 1'b1;
          state_next    = S_EXP;
        end
      end
      S_TEST: begin
        if (stat.r_one) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else begin
          state_next = S_SQ_CHK;
        end
      end
      S_SQ_CHK: begin
        if (stat.s_zero) begin
          fin = 1'b1;
        end else if (stat.r_nm1) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.op       = sppt_pkg::OP_SQR;
          cmd.s_dec    = 1'b1;
          state_next   = S_SQR_W;
        end
      end
      S_SQR_W: begin
        if (stat.mm_done) state_next = S_SQ_CHK;
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) is_probable_prime <= fin_val;
  end

endmodule
`default_nettype wire

@@ design/strong_probable_prime_test.sv @@
// Top level of the single-base strong probable prime (Miller-Rabin) test.
// Sequence: n below 3 is settled by the check alone; otherwise n-1 is split,
// then one modular multiply runs per step, each with a doubling per bit of the
// multiplier and an add per set bit; at most about 128 multiplies in all.
// Throughput: one item at a time, set by the shared bit-serial multiplier.
// Reset (rst, synchronous): sequencer to idle, no result pending.
`default_nettype none
module strong_probable_prime_test (
  input  wire logic            clk,
  input  wire logic            rst,
  // item in: accepted when start is high and busy is low
  input  wire logic            start,
  input  wire sppt_pkg::word_t candidate,
  input  wire sppt_pkg::word_t base,
  output logic                 busy,
  // result: valid for exactly the one cycle that done is high
  output logic                 done,
  output logic                 is_probable_prime
);

  sppt_pkg::cmd_t  cmd;
  sppt_pkg::stat_t stat;

  // Sequencer: splits n-1 into d * 2^s, reduces the base, runs the
  // right-to-left exponentiation, then up to s squarings compared with n-1.
  sppt_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .stat              (stat),
    .cmd               (cmd),
    .busy              (busy),
    .done              (done),
    .is_probable_prime (is_probable_prime)
  );

  // Datapath: operand registers and the shared modular multiplier.
  // The base reduction reuses the multiplier as 1 * base mod n.
  sppt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .candidate (candidate),
    .base      (base),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

@@ design/sppt_checker.sv @@
// Port-level checks for the strong probable prime test, bound to the top level.
`default_nettype none
module sppt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // the result appears exactly as the block goes idle
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  // a result never shows while work is still under way
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // no result is invented while idle with no item taken
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !done)
    else $error("result without an item");

  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("reset did not clear the block");

endmodule

bind strong_probable_prime_test sppt_checker u_sppt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire

@@ tb/strong_probable_prime_test_tb.sv @@
// Self-checking testbench for the single-base strong probable prime test.
`timescale 1ns / 100ps

module strong_probable_prime_test_tb;

  // A full item needs at most about 128 multiplies (exponent steps plus
  // squarings), each bit-serial over the 64-bit multiplier. The watchdog fails
  // the run when quiet_cycles, which counts time with no accepted item and no
  // result, reaches STALL_LIMIT.
  localparam int STALL_LIMIT = 200_000;
  // Cycles to linger once nothing is outstanding, in case a stray result follows.
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 75;

  typedef bit [sppt_pkg::WIDTH-1:0]   num_t;
  typedef bit [2*sppt_pkg::WIDTH-1:0] wide_t;

  typedef struct {
    sppt_pkg::word_t candidate;
    sppt_pkg::word_t base;
  } trial_t;

  typedef struct {
    sppt_pkg::word_t candidate;
    sppt_pkg::word_t base;
    bit              verdict;
  } verdict_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  sppt_pkg::word_t candidate = '0;
  sppt_pkg::word_t base = '0;
  logic            busy;
  logic            done;
  logic            is_probable_prime;

  trial_t   pending_trials[$];     // items still to be offered
  verdict_t expected_verdicts[$];  // verdicts owed by the block, oldest first

  int items_accepted = 0;
  int quiet_cycles = 0;
  int idle_left = 0;
  bit failed = 1'b0;

  strong_probable_prime_test dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .candidate         (candidate),
    .base              (base),
    .busy              (busy),
    .done              (done),
    .is_probable_prime (is_probable_prime)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: plain wide arithmetic rather than the block's bit-serial form.
  // ---------------------------------------------------------------------------

  // (a * b) mod m through a double-width product
  function automatic num_t modmul(num_t a, num_t b, num_t m);
    wide_t prod;
    prod = wide_t'(a) * wide_t'(b);
    return num_t'(prod % wide_t'(m));
  endfunction

  // b^e mod m, right-to-left square and multiply; b < m and m >= 3
  function automatic num_t modexp(num_t b, num_t e, num_t m);
    num_t acc;
    acc = 1;
    while (e != 0) begin
      if (e[0])
        acc = modmul(acc, b, m);
      b = modmul(b, b, m);
      e >>= 1;
    end
    return acc;
  endfunction

  // Verdict for one item: is n a strong probable prime to base b?
  function automatic bit sprp_verdict(num_t n, num_t b);
    num_t odd_part;
    num_t x;
    num_t n_less_1;
    int   twos;
    if (n < 3)
      return n == 2;
    n_less_1 = n - 1;
    odd_part = n_less_1;
    twos = 0;
    while (!odd_part[0]) begin
      odd_part >>= 1;
      twos++;
    end
    x = modexp(b % n, odd_part, n);
    if (x == 1)
      return 1'b1;
    // n-1 counts before each squaring only; the value after the last one
    // is never compared
    for (int i = 0; i < twos; i++) begin
      if (x == n_less_1)
        return 1'b1;
      x = modmul(x, x, n);
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic num_t random_bits(int bits);
    num_t v;
    v = {$urandom, $urandom};
    if (bits < sppt_pkg::WIDTH)
      v &= (num_t'(1) << bits) - 1;
    return v;
  endfunction

  // Random prime with its top bit at position bits-1 (bits >= 4). Four bases
  // are plenty to weed out composites at these sizes, and a rare miss only
  // turns the item into an odd composite, which is still a fair test.
  function automatic num_t random_prime(int bits);
    num_t n;
    n = 0;
    repeat (4000) begin
      n = random_bits(bits) | num_t'(1) | (num_t'(1) << (bits - 1));
      if (sprp_verdict(n, 2) && sprp_verdict(n, 3) && sprp_verdict(n, 5) &&
          sprp_verdict(n, 7))
        return n;
    end
    return n;
  endfunction

  task automatic queue_trial(sppt_pkg::word_t n, sppt_pkg::word_t b);
    pending_trials.push_back('{n, b});
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pending_trials, with random hold-offs. An item
  // leaves the queue at the edge where start is high and busy is low. Start
  // may drop while the block is busy, so gaps land on every phase of its work.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy)
        void'(pending_trials.pop_front());
      if (pending_trials.size() == 0) begin
        start <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (!(items_accepted >= 30 && items_accepted < 70) &&
                   $urandom_range(99) < 2) begin
        // start a random hold-off, but none in the middle of the run
        idle_left = $urandom_range(6);
        start <= 1'b0;
      end else begin
        start     <= 1'b1;
        candidate <= pending_trials[0].candidate;
        base      <= pending_trials[0].base;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts each accepted item, checks each result against the
  // oldest prediction, and runs the watchdog. Both sides live in one block,
  // so an item accepted at the edge of a result cannot race the check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_verdicts.push_back('{candidate, base,
                                      sprp_verdict(candidate, base)});
        items_accepted <= items_accepted + 1;
      end
      if (done) begin
        if (expected_verdicts.size() == 0) begin
          $error("is_probable_prime: result with no item outstanding (actual %b)",
                 is_probable_prime);
          failed = 1'b1;
        end else begin
          if (is_probable_prime !== expected_verdicts[0].verdict) begin
            $error("is_probable_prime: n=%0d b=%0d expected %b actual %b",
                   expected_verdicts[0].candidate, expected_verdicts[0].base,
                   expected_verdicts[0].verdict, is_probable_prime);
            failed = 1'b1;
          end
          void'(expected_verdicts.pop_front());
        end
      end
      if ((start && !busy) || done)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** strong_probable_prime_test: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    num_t top_prime;
    num_t n;
    num_t b;
    int   bits;

    top_prime = 64'd18446744073709551557;  // largest prime below 2^64

    // Directed: small candidates, bases that are multiples of n, even
    // candidates (no squarings, so a final value of n-1 still fails),
    // n-1 reached only after a squaring, strong pseudoprimes, extremes.
    queue_trial(0, 0);
    queue_trial(1, '1);
    queue_trial(2, '1);
    queue_trial(2, 0);
    queue_trial(3, 2);
    queue_trial(3, 3);
    queue_trial(4, 1);
    queue_trial(4, 3);
    queue_trial(10, 9);
    queue_trial(13, 2);
    queue_trial(7, 14);
    queue_trial(2047, 2);
    queue_trial(2047, 3);
    queue_trial(561, 2);
    queue_trial(64'd3215031751, 2);
    queue_trial(64'd3215031751, 11);
    queue_trial('1, '1);
    queue_trial('1, 2);
    queue_trial(top_prime, 2);
    queue_trial(top_prime, '1);
    queue_trial(top_prime, top_prime - 1);
    queue_trial(top_prime, 1);
    queue_trial(top_prime, 0);
    queue_trial(64'h8000_0000_0000_0000, 3);
    queue_trial(top_prime, {$urandom, $urandom});

    // Random: primes of varied size most often, since those pass for any base
    // not a multiple of n; then composites, even and small candidates, and
    // awkward bases.
    repeat (RANDOM_ITEMS) begin
      bits = $urandom_range(4, sppt_pkg::WIDTH);
      case ($urandom_range(99)) inside
        [0:39]: begin
          n = random_prime(bits);
          b = {$urandom, $urandom};
        end
        [40:54]: begin
          n = random_bits(bits) | num_t'(1);
          b = {$urandom, $urandom};
        end
        [55:66]: begin
          // semiprime from two primes of up to half width
          n = random_prime($urandom_range(4, sppt_pkg::WIDTH / 2)) *
              random_prime($urandom_range(4, sppt_pkg::WIDTH / 2));
          b = $urandom_range(1) ? num_t'(2) : num_t'({$urandom, $urandom});
        end
        [67:76]: begin
          n = (random_bits(bits) & ~num_t'(1)) | num_t'(4);
          b = $urandom_range(3) == 0 ? num_t'(1) : num_t'({$urandom, $urandom});
        end
        [77:84]: begin
          n = num_t'($urandom_range(16));
          b = {$urandom, $urandom};
        end
        default: begin
          n = $urandom_range(1) ? random_prime(bits) : random_bits(bits) | num_t'(1);
          case ($urandom_range(5))
            0:       b = 0;
            1:       b = 1;
            2:       b = n - 1;
            3:       b = n;
            4:       b = n * num_t'($urandom_range(2, 1000));
            default: b = '1;
          endcase
        end
      endcase
      queue_trial(n, b);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge, clear of the accept and result edges.
    while (pending_trials.size() != 0 || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (!failed)
      $display("** strong_probable_prime_test: PASSED **");
    else
      $display("** strong_probable_prime_test: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
design/sppt_pkg.sv
design/sppt_modmul.sv
design/sppt_datapath.sv
design/sppt_ctrl.sv
design/strong_probable_prime_test.sv
design/sppt_checker.sv
tb/strong_probable_prime_test_tb.sv
